// File: rtl/jerk_limited_yaw_profiler_top_defines.svh
// ----------------------------------------------------------------------------
// Yaw profiler assertion macros
// Shared property forms for the yaw profiler checker.
// ----------------------------------------------------------------------------
`ifndef JERK_LIMITED_YAW_PROFILER_TOP_DEFINES_SVH
`define JERK_LIMITED_YAW_PROFILER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JLYP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jlyp checker: same-cycle property violated");

// Consequent must hold in the cycle after the antecedent.
`define JLYP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jlyp checker: next-cycle property violated");

`endif

// File: rtl/jlyp_pkg.sv
// ----------------------------------------------------------------------------
// Yaw profiler package
// Widths, constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package jlyp_pkg;

    localparam int YAW_W   = 25;
    localparam int RATE_W  = 27;
    localparam int ACC_W   = 31;
    localparam int MR_W    = 26;
    localparam int MA_W    = 30;
    localparam int MJ_W    = 30;
    localparam int DT_W    = 16;
    localparam int CFG_W   = 30;
    localparam int IDX_W   = 2;
    localparam int WV_W    = 28;
    localparam int MUL_W   = 48;
    localparam int DIGIT_W = 16;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int NDIGIT  = MUL_W / DIGIT_W;
    localparam int DCNT_W  = $clog2(NDIGIT);
    localparam int W_W     = MA_W + 16;
    localparam int DIVC_W  = $clog2(W_W);
    localparam int CAP_W   = 47;
    localparam int SUM_W   = 49;
    localparam int AM2_W   = 62;
    localparam int JD_W    = MJ_W + DT_W;

    localparam logic signed [WV_W-1:0]   DEG180   = 28'sd11796480;
    localparam logic signed [WV_W-1:0]   DEG360   = 28'sd23592960;
    localparam logic signed [RATE_W-1:0] RATE_SAT = 27'sd65536000;
    localparam logic [CAP_W-1:0]         MAG_CAP  = 47'd70368744177664;

    localparam logic [MR_W-1:0] RST_MAX_RATE  = 26'd5898240;
    localparam logic [MA_W-1:0] RST_MAX_ACCEL = 30'd2949120;
    localparam logic [MJ_W-1:0] RST_MAX_JERK  = 30'd5898240;

    localparam logic [IDX_W-1:0] CFG_MAX_RATE  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_ACCEL = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_JERK  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_DIV,
        S_MWW,
        S_MT1,
        S_MT2,
        S_MAA,
        S_MMJ,
        S_MJD,
        S_MJDD,
        S_ACC,
        S_MAD,
        S_MRD,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// File: rtl/jlyp_mul.sv
// ----------------------------------------------------------------------------
// Yaw profiler multiplier
// Unsigned multiplier that takes one 16-bit digit of the second operand
// per cycle and accumulates the partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module jlyp_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [jlyp_pkg::MUL_W-1:0]   i_a,
    input  wire logic [jlyp_pkg::MUL_W-1:0]   i_b,
    output logic                              o_done,
    output logic [jlyp_pkg::PROD_W-1:0]       o_prod
);

    logic                                r_busy;
    logic                                r_done;
    logic [jlyp_pkg::DCNT_W-1:0]         r_cnt;
    logic [jlyp_pkg::MUL_W-1:0]          r_a;
    logic [jlyp_pkg::MUL_W-1:0]          r_b;
    logic [jlyp_pkg::PROD_W-1:0]         r_acc;
    logic [jlyp_pkg::MUL_W+jlyp_pkg::DIGIT_W-1:0] pp;
    logic [jlyp_pkg::PROD_W-1:0]         pp_sh;

    // The digit position is the digit count times the digit width.
    assign pp    = r_a * r_b[jlyp_pkg::DIGIT_W-1:0];
    assign pp_sh = jlyp_pkg::PROD_W'(pp) << (7'(r_cnt) * 7'(jlyp_pkg::DIGIT_W));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == jlyp_pkg::DCNT_W'(jlyp_pkg::NDIGIT - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
            r_b   <= r_b >> jlyp_pkg::DIGIT_W;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// File: rtl/jlyp_div.sv
// ----------------------------------------------------------------------------
// Yaw profiler divider
// Restoring divider that forms one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jlyp_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [jlyp_pkg::W_W-1:0]    i_dividend,
    input  wire logic [jlyp_pkg::MR_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [jlyp_pkg::W_W-1:0]         o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [jlyp_pkg::DIVC_W-1:0]   r_cnt;
    logic [jlyp_pkg::MR_W-1:0]     r_div;
    logic [jlyp_pkg::MR_W-1:0]     r_rem;
    logic [jlyp_pkg::W_W-1:0]      r_q;
    logic [jlyp_pkg::MR_W:0]       sh;
    logic [jlyp_pkg::MR_W:0]       trial;
    logic                          ge;

    assign sh    = {r_rem, r_q[jlyp_pkg::W_W-1]};
    assign ge    = sh >= {1'b0, r_div};
    assign trial = sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == jlyp_pkg::DIVC_W'(jlyp_pkg::W_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? trial[jlyp_pkg::MR_W-1:0] : sh[jlyp_pkg::MR_W-1:0];
            r_q   <= {r_q[jlyp_pkg::W_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: rtl/jerk_limited_yaw_profiler_top.sv
// ----------------------------------------------------------------------------
// Jerk-limited yaw profiler
// Heading setpoint generator with rate, acceleration and jerk limits.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with exactly one
// result. A load request (func 1) sets heading and rate and clears the
// acceleration. A profile request while nothing has been loaded, or with dt
// zero, answers with the state unchanged. A full profile step runs the
// 46-step restoring divider that forms the damping frequency, up to nine
// products on the shared 48x16 digit multiplier, and the heading wrap.
// Without a jerk limit four of those products are skipped. With a zero rate
// or acceleration limit the divider and the first three products are skipped.
// Input ready is high only while the block is idle, and the result stays on
// the output until it is taken. Configuration writes are always accepted and
// should be made only while the block is idle; a write to an index beyond
// the three registers is ignored. Heading, rate and acceleration are signed
// Q16.16, the limits are unsigned Q16.16, and dt is unsigned Q0.16.
// ----------------------------------------------------------------------------
`default_nettype none

module jerk_limited_yaw_profiler_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_func,
    input  wire logic signed [jlyp_pkg::YAW_W-1:0]    i_target_yaw,
    input  wire logic signed [jlyp_pkg::RATE_W-1:0]   i_target_yaw_rate,
    input  wire logic                                 i_target_valid,
    input  wire logic [jlyp_pkg::DT_W-1:0]            i_dt,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [jlyp_pkg::YAW_W-1:0]         o_yaw,
    output logic signed [jlyp_pkg::RATE_W-1:0]        o_yaw_rate,
    output logic signed [jlyp_pkg::ACC_W-1:0]         o_yaw_accel,
    output logic                                      o_valid_res,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [jlyp_pkg::IDX_W-1:0]           i_cfg_index,
    input  wire logic [jlyp_pkg::CFG_W-1:0]           i_cfg_data
);

    // Sequencer.
    jlyp_pkg::t_state r_state;
    jlyp_pkg::t_state n_state;
    logic             r_wait;
    logic             r_hd_mode;

    // Architectural state and configuration.
    logic signed [jlyp_pkg::YAW_W-1:0]  r_heading;
    logic signed [jlyp_pkg::RATE_W-1:0] r_rate;
    logic signed [jlyp_pkg::ACC_W-1:0]  r_accel;
    logic                               r_loaded;
    logic [jlyp_pkg::MR_W-1:0]          r_max_rate;
    logic [jlyp_pkg::MA_W-1:0]          r_max_accel;
    logic [jlyp_pkg::MJ_W-1:0]          r_max_jerk;

    // Per-request working registers.
    logic [jlyp_pkg::DT_W-1:0]          r_dt;
    logic signed [jlyp_pkg::RATE_W-1:0] r_tr;
    logic signed [jlyp_pkg::WV_W-1:0]   r_wv;
    logic signed [jlyp_pkg::YAW_W-1:0]  r_err;
    logic [jlyp_pkg::W_W-1:0]           r_w;
    logic [jlyp_pkg::CAP_W-1:0]         r_ww;
    logic signed [jlyp_pkg::SUM_W-1:0]  r_t1;
    logic signed [jlyp_pkg::ACC_W-1:0]  r_des;
    logic [jlyp_pkg::AM2_W-1:0]         r_am2;
    logic                               r_relok;
    logic [jlyp_pkg::JD_W-1:0]          r_jd;
    logic [jlyp_pkg::MJ_W-1:0]          r_step;
    logic [jlyp_pkg::MJ_W-1:0]          r_slack;

    // Shared units.
    logic                           mul_start;
    logic                           mul_done;
    logic [jlyp_pkg::MUL_W-1:0]     mul_a;
    logic [jlyp_pkg::MUL_W-1:0]     mul_b;
    logic [jlyp_pkg::PROD_W-1:0]    mul_prod;
    logic                           div_start;
    logic                           div_done;
    logic [jlyp_pkg::W_W-1:0]       div_quot;

    // Datapath helpers.
    logic                                  accept;
    logic                                  limits_ok;
    logic                                  jerk_on;
    logic signed [jlyp_pkg::RATE_W-1:0]    rlim;
    logic signed [jlyp_pkg::RATE_W-1:0]    tr_clamp;
    logic signed [jlyp_pkg::RATE_W-1:0]    load_rate;
    logic signed [jlyp_pkg::WV_W-1:0]      load_yaw;
    logic                                  wrap_done;
    logic signed [jlyp_pkg::WV_W-1:0]      wrap_fin;
    logic [jlyp_pkg::YAW_W-1:0]            err_mag;
    logic signed [jlyp_pkg::WV_W-1:0]      d_tr;
    logic [jlyp_pkg::WV_W-1:0]             d_mag;
    logic [jlyp_pkg::PROD_W-17:0]          p16;
    logic [jlyp_pkg::CAP_W-1:0]            psat;
    logic signed [jlyp_pkg::SUM_W-1:0]     psat_s;
    logic signed [jlyp_pkg::SUM_W-1:0]     t2;
    logic signed [jlyp_pkg::SUM_W-1:0]     sum;
    logic signed [jlyp_pkg::SUM_W-1:0]     alim;
    logic signed [jlyp_pkg::SUM_W-1:0]     des_c;
    logic [jlyp_pkg::RATE_W-1:0]           rate_mag;
    logic [jlyp_pkg::ACC_W-1:0]            accel_mag;
    logic signed [jlyp_pkg::WV_W-1:0]      margin_d;
    logic [jlyp_pkg::MR_W-1:0]             margin;
    logic                                  out_pos;
    logic                                  out_neg;
    logic                                  des_out;
    logic                                  acc_out;
    logic                                  cut;
    logic signed [31:0]                    dsel;
    logic signed [31:0]                    delta;
    logic signed [31:0]                    step_s;
    logic signed [31:0]                    delta_c;
    logic signed [31:0]                    accel_new;
    logic [jlyp_pkg::ACC_W-1:0]            pa;
    logic signed [32:0]                    rate_sum;
    logic signed [jlyp_pkg::RATE_W-1:0]    rate_new;
    logic [jlyp_pkg::RATE_W-1:0]           pr;
    logic signed [jlyp_pkg::WV_W-1:0]      head_sum;

    jlyp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    jlyp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_max_accel, 16'd0}),
        .i_divisor  (r_max_rate),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign accept    = i_valid && o_ready;
    assign limits_ok = (r_max_rate != '0) && (r_max_accel != '0);
    assign jerk_on   = r_max_jerk != '0;

    // Target rate is limited to the configured rate; a load uses the fixed
    // saturation instead. A loaded heading is below one turn in magnitude,
    // so only the half-turn fold in the wrap state applies to it.
    assign rlim      = $signed({1'b0, r_max_rate});
    assign tr_clamp  = (i_target_yaw_rate > rlim) ? rlim :
                       (i_target_yaw_rate < -rlim) ? -rlim : i_target_yaw_rate;
    assign load_rate = (i_target_yaw_rate > jlyp_pkg::RATE_SAT) ? jlyp_pkg::RATE_SAT :
                       (i_target_yaw_rate < -jlyp_pkg::RATE_SAT) ? -jlyp_pkg::RATE_SAT :
                       i_target_yaw_rate;
    assign load_yaw  = jlyp_pkg::WV_W'(i_target_yaw);

    // Wrapping removes whole turns toward zero, one per cycle, and then
    // folds the result into the half-open range above minus one half turn.
    assign wrap_done = (r_wv < jlyp_pkg::DEG360) && (r_wv > -jlyp_pkg::DEG360);
    assign wrap_fin  = (r_wv > jlyp_pkg::DEG180) ? r_wv - jlyp_pkg::DEG360 :
                       (r_wv <= -jlyp_pkg::DEG180) ? r_wv + jlyp_pkg::DEG360 : r_wv;

    // Product scaling: a Q16.16 product is shifted down and its magnitude
    // capped at two to the 46th.
    assign p16    = mul_prod[jlyp_pkg::PROD_W-1:16];
    assign psat   = (p16 > (jlyp_pkg::PROD_W-16)'(jlyp_pkg::MAG_CAP)) ? jlyp_pkg::MAG_CAP :
                    p16[jlyp_pkg::CAP_W-1:0];
    assign psat_s = $signed(jlyp_pkg::SUM_W'(psat));

    assign err_mag = (r_err < 0) ? jlyp_pkg::YAW_W'(-r_err) : jlyp_pkg::YAW_W'(r_err);
    assign d_tr    = jlyp_pkg::WV_W'(r_tr) - jlyp_pkg::WV_W'(r_rate);
    assign d_mag   = (d_tr < 0) ? jlyp_pkg::WV_W'(-d_tr) : jlyp_pkg::WV_W'(d_tr);

    assign t2    = (d_tr < 0) ? -psat_s : psat_s;
    assign sum   = r_t1 + t2;
    assign alim  = $signed(jlyp_pkg::SUM_W'(r_max_accel));
    assign des_c = (sum > alim) ? alim : (sum < -alim) ? -alim : sum;

    assign rate_mag  = (r_rate < 0) ? jlyp_pkg::RATE_W'(-r_rate) : jlyp_pkg::RATE_W'(r_rate);
    assign accel_mag = (r_accel < 0) ? jlyp_pkg::ACC_W'(-r_accel) : jlyp_pkg::ACC_W'(r_accel);
    assign margin_d  = $signed({2'b00, r_max_rate}) - $signed({1'b0, rate_mag});
    assign margin    = (margin_d < 0) ? '0 : margin_d[jlyp_pkg::MR_W-1:0];

    // Outward is the direction of the rate, or of the demand at zero rate.
    // Demand pushing outward is dropped when braking could not stop in time.
    assign out_pos = (r_rate > 0) || ((r_rate == 0) && (r_des > 0));
    assign out_neg = (r_rate < 0) || ((r_rate == 0) && (r_des < 0));
    assign des_out = ((r_des > 0) && out_pos) || ((r_des < 0) && out_neg);
    assign acc_out = ((r_accel > 0) && out_pos) || ((r_accel < 0) && out_neg);
    assign cut     = des_out && ((acc_out && r_relok) ||
                                 (jlyp_pkg::MJ_W'(margin) <= r_slack));

    assign dsel      = cut ? 32'sd0 : 32'(r_des);
    assign delta     = dsel - 32'(r_accel);
    assign step_s    = $signed(32'(r_step));
    assign delta_c   = (delta > step_s) ? step_s : (delta < -step_s) ? -step_s : delta;
    assign accel_new = 32'(r_accel) + delta_c;

    // Rate and heading integration.
    assign pa       = mul_prod[46:16];
    assign rate_sum = (r_accel < 0) ? 33'(r_rate) - $signed(33'(pa)) :
                                      33'(r_rate) + $signed(33'(pa));
    assign rate_new = (rate_sum > 33'(jlyp_pkg::RATE_SAT)) ? jlyp_pkg::RATE_SAT :
                      (rate_sum < -33'(jlyp_pkg::RATE_SAT)) ? -jlyp_pkg::RATE_SAT :
                      jlyp_pkg::RATE_W'(rate_sum);
    assign pr       = mul_prod[42:16];
    assign head_sum = (r_rate < 0) ?
                      jlyp_pkg::WV_W'(r_heading) - $signed(jlyp_pkg::WV_W'(pr)) :
                      jlyp_pkg::WV_W'(r_heading) + $signed(jlyp_pkg::WV_W'(pr));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            jlyp_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_func) begin
                        n_state = jlyp_pkg::S_WRAP;
                    end else if (!r_loaded || (i_dt == '0)) begin
                        n_state = jlyp_pkg::S_OUT;
                    end else begin
                        n_state = jlyp_pkg::S_WRAP;
                    end
                end
            end
            jlyp_pkg::S_WRAP: begin
                if (wrap_done) begin
                    if (r_hd_mode) begin
                        n_state = jlyp_pkg::S_OUT;
                    end else if (limits_ok) begin
                        n_state = jlyp_pkg::S_DIV;
                    end else if (jerk_on) begin
                        n_state = jlyp_pkg::S_MAA;
                    end else begin
                        n_state = jlyp_pkg::S_MAD;
                    end
                end
            end
            jlyp_pkg::S_DIV:  if (div_done) n_state = jlyp_pkg::S_MWW;
            jlyp_pkg::S_MWW:  if (mul_done) n_state = jlyp_pkg::S_MT1;
            jlyp_pkg::S_MT1:  if (mul_done) n_state = jlyp_pkg::S_MT2;
            jlyp_pkg::S_MT2: begin
                if (mul_done) begin
                    n_state = jerk_on ? jlyp_pkg::S_MAA : jlyp_pkg::S_MAD;
                end
            end
            jlyp_pkg::S_MAA:  if (mul_done) n_state = jlyp_pkg::S_MMJ;
            jlyp_pkg::S_MMJ:  if (mul_done) n_state = jlyp_pkg::S_MJD;
            jlyp_pkg::S_MJD:  if (mul_done) n_state = jlyp_pkg::S_MJDD;
            jlyp_pkg::S_MJDD: if (mul_done) n_state = jlyp_pkg::S_ACC;
            jlyp_pkg::S_ACC:  n_state = jlyp_pkg::S_MAD;
            jlyp_pkg::S_MAD:  if (mul_done) n_state = jlyp_pkg::S_MRD;
            jlyp_pkg::S_MRD:  if (mul_done) n_state = jlyp_pkg::S_WRAP;
            jlyp_pkg::S_OUT:  if (i_ready) n_state = jlyp_pkg::S_IDLE;
            default:          n_state = jlyp_pkg::S_IDLE;
        endcase
    end

    // State-decoded outputs and multiplier operand selection.
    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            jlyp_pkg::S_IDLE: o_ready = 1'b1;
            jlyp_pkg::S_OUT:  o_valid = 1'b1;
            jlyp_pkg::S_DIV:  div_start = !r_wait;
            jlyp_pkg::S_MWW: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'(r_w);
                mul_b     = jlyp_pkg::MUL_W'(r_w);
            end
            jlyp_pkg::S_MT1: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'(r_ww);
                mul_b     = jlyp_pkg::MUL_W'(err_mag);
            end
            jlyp_pkg::S_MT2: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'({r_w, 1'b0});
                mul_b     = jlyp_pkg::MUL_W'(d_mag);
            end
            jlyp_pkg::S_MAA: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'(accel_mag);
                mul_b     = jlyp_pkg::MUL_W'(accel_mag);
            end
            jlyp_pkg::S_MMJ: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'(margin);
                mul_b     = jlyp_pkg::MUL_W'({r_max_jerk, 1'b0});
            end
            jlyp_pkg::S_MJD: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'(r_max_jerk);
                mul_b     = jlyp_pkg::MUL_W'(r_dt);
            end
            jlyp_pkg::S_MJDD: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'(r_jd);
                mul_b     = jlyp_pkg::MUL_W'(r_dt);
            end
            jlyp_pkg::S_MAD: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'(accel_mag);
                mul_b     = jlyp_pkg::MUL_W'(r_dt);
            end
            jlyp_pkg::S_MRD: begin
                mul_start = !r_wait;
                mul_a     = jlyp_pkg::MUL_W'(rate_mag);
                mul_b     = jlyp_pkg::MUL_W'(r_dt);
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // Control state, architectural state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jlyp_pkg::S_IDLE;
            r_wait      <= 1'b0;
            r_hd_mode   <= 1'b0;
            r_heading   <= '0;
            r_rate      <= '0;
            r_accel     <= '0;
            r_loaded    <= 1'b0;
            r_max_rate  <= jlyp_pkg::RST_MAX_RATE;
            r_max_accel <= jlyp_pkg::RST_MAX_ACCEL;
            r_max_jerk  <= jlyp_pkg::RST_MAX_JERK;
        end else begin
            r_state <= n_state;
            if (mul_start || div_start) begin
                r_wait <= 1'b1;
            end else if (mul_done || div_done) begin
                r_wait <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    jlyp_pkg::CFG_MAX_RATE:  r_max_rate  <= i_cfg_data[jlyp_pkg::MR_W-1:0];
                    jlyp_pkg::CFG_MAX_ACCEL: r_max_accel <= i_cfg_data[jlyp_pkg::MA_W-1:0];
                    jlyp_pkg::CFG_MAX_JERK:  r_max_jerk  <= i_cfg_data[jlyp_pkg::MJ_W-1:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                jlyp_pkg::S_IDLE: begin
                    if (accept) begin
                        r_hd_mode <= i_func;
                        if (i_func) begin
                            r_rate   <= load_rate;
                            r_accel  <= '0;
                            r_loaded <= 1'b1;
                        end
                    end
                end
                jlyp_pkg::S_WRAP: begin
                    if (wrap_done) begin
                        if (r_hd_mode) begin
                            r_heading <= jlyp_pkg::YAW_W'(wrap_fin);
                        end else if (!limits_ok && !jerk_on) begin
                            r_accel <= '0;
                        end
                    end
                end
                jlyp_pkg::S_MT2: begin
                    if (mul_done && !jerk_on) begin
                        r_accel <= jlyp_pkg::ACC_W'(des_c);
                    end
                end
                jlyp_pkg::S_ACC: r_accel <= jlyp_pkg::ACC_W'(accel_new);
                jlyp_pkg::S_MAD: if (mul_done) r_rate <= rate_new;
                jlyp_pkg::S_MRD: if (mul_done) r_hd_mode <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        case (r_state)
            jlyp_pkg::S_IDLE: begin
                if (accept) begin
                    r_dt <= i_dt;
                    if (i_func) begin
                        r_wv <= load_yaw;
                    end else if (i_target_valid) begin
                        r_wv <= jlyp_pkg::WV_W'(i_target_yaw) - jlyp_pkg::WV_W'(r_heading);
                        r_tr <= tr_clamp;
                    end else begin
                        r_wv <= '0;
                        r_tr <= '0;
                    end
                end
            end
            jlyp_pkg::S_WRAP: begin
                if (!wrap_done) begin
                    r_wv <= (r_wv < 0) ? r_wv + jlyp_pkg::DEG360 : r_wv - jlyp_pkg::DEG360;
                end else begin
                    r_err <= jlyp_pkg::YAW_W'(wrap_fin);
                    if (!limits_ok) begin
                        r_des <= '0;
                    end
                end
            end
            jlyp_pkg::S_DIV:  if (div_done) r_w <= div_quot;
            jlyp_pkg::S_MWW:  if (mul_done) r_ww <= psat;
            jlyp_pkg::S_MT1:  if (mul_done) r_t1 <= (r_err < 0) ? -psat_s : psat_s;
            jlyp_pkg::S_MT2:  if (mul_done) r_des <= jlyp_pkg::ACC_W'(des_c);
            jlyp_pkg::S_MAA:  if (mul_done) r_am2 <= mul_prod[jlyp_pkg::AM2_W-1:0];
            jlyp_pkg::S_MMJ: begin
                if (mul_done) begin
                    r_relok <= r_am2 >= mul_prod[jlyp_pkg::AM2_W-1:0];
                end
            end
            jlyp_pkg::S_MJD: begin
                if (mul_done) begin
                    r_jd   <= mul_prod[jlyp_pkg::JD_W-1:0];
                    r_step <= mul_prod[jlyp_pkg::JD_W-1:16];
                end
            end
            jlyp_pkg::S_MJDD: if (mul_done) r_slack <= mul_prod[61:32];
            jlyp_pkg::S_MRD:  if (mul_done) r_wv <= head_sum;
            default: begin
            end
        endcase
    end

    assign o_yaw       = r_heading;
    assign o_yaw_rate  = r_rate;
    assign o_yaw_accel = r_accel;
    assign o_valid_res = r_loaded;

endmodule

`default_nettype wire

// File: rtl/jlyp_checker.sv
// ----------------------------------------------------------------------------
// Yaw profiler checker
// Port-level properties of the yaw profiler, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "jerk_limited_yaw_profiler_top_defines.svh"

module jlyp_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_ready,
    input wire logic                               o_valid,
    input wire logic                               i_ready,
    input wire logic signed [jlyp_pkg::YAW_W-1:0]  o_yaw,
    input wire logic signed [jlyp_pkg::RATE_W-1:0] o_yaw_rate,
    input wire logic signed [jlyp_pkg::ACC_W-1:0]  o_yaw_accel,
    input wire logic                               o_valid_res
);

    // A pending result is not withdrawn and does not change.
    `JLYP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `JLYP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_yaw) && $stable(o_yaw_rate) && $stable(o_yaw_accel) && $stable(o_valid_res))

    // One request at a time: no new request while a result is pending, and
    // the block is busy right after taking a request.
    `JLYP_ASSERT_SAME(a_one_at_a_time, i_clk, i_rst_n, o_ready, !o_valid)
    `JLYP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // Once loaded, the block stays loaded until reset.
    `JLYP_ASSERT_NEXT(a_loaded_sticky, i_clk, i_rst_n, o_valid_res, o_valid_res)

endmodule

bind jerk_limited_yaw_profiler_top jlyp_checker u_jlyp_checker (.*);

`default_nettype wire
